[rtl/rip_pkg.sv]
// shared types and constants for the record and interpolated playback core
`default_nettype none

package rip_pkg;

    localparam int ACTION_W    = 3;
    localparam int SAMPLE_W    = 16;
    localparam int LEN_FIELD_W = 15;
    localparam int STEP_W      = 20;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_IDX_W   = 1;

    localparam logic [STEP_W-1:0] STEP_RESET = 20'h10000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 1'b1;

    // action codes of an input item
    localparam logic [ACTION_W-1:0] ACT_BEGIN   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_RECORD  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RESTART = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PROCESS = 3'd4;

    // status of the wrap unit
    typedef struct packed {
        logic busy;
        logic done;
    } wrap_stat_t;

endpackage

`default_nettype wire

[rtl/rip_table.sv]
// sample table memory with a fill count standing in for the zero reset
`default_nettype none

module rip_table #(
    parameter int DEPTH  = 16384,
    parameter int IDX_W  = 14,
    parameter int FILL_W = 15
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [IDX_W-1:0]              wr_addr,
    input  wire logic [rip_pkg::SAMPLE_W-1:0]  wr_data,
    input  wire logic [IDX_W-1:0]              rd_addr,
    output logic      [rip_pkg::SAMPLE_W-1:0]  rd_data
);

    logic [rip_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic [rip_pkg::SAMPLE_W-1:0] mem_q;
    logic                         rd_ok_reg;
    logic [FILL_W-1:0]            fill_reg;
    logic [FILL_W-1:0]            fill_next;

    // writes only ever land at the fill count or below it, so the
    // written entries always form a prefix of the table
    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && (FILL_W'(wr_addr) == fill_reg))
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            rd_ok_reg <= (FILL_W'(rd_addr) < fill_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q <= mem[rd_addr];
    end

    // entries never written read as zero
    assign rd_data = rd_ok_reg ? mem_q : '0;

endmodule

`default_nettype wire

[rtl/rip_wrap.sv]
// iterative remainder unit: one shifted compare and subtract per cycle
`default_nettype none

module rip_wrap #(
    parameter int VAL_W = 15,
    parameter int LEN_W = 15,
    parameter int K_W   = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [VAL_W-1:0]  start_val,
    input  wire logic [K_W-1:0]    start_k,
    input  wire logic [LEN_W-1:0]  len,
    output rip_pkg::wrap_stat_t    stat,
    output logic      [VAL_W-1:0]  rem
);

    localparam int D_W = LEN_W + VAL_W;

    logic [VAL_W-1:0] rem_reg;
    logic [VAL_W-1:0] rem_next;
    logic [K_W-1:0]   k_reg;
    logic [K_W-1:0]   k_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [D_W-1:0]   dshift;
    logic [D_W-1:0]   rem_ext;

    // start_k is chosen so that the value is below len << (start_k + 1)
    assign dshift  = D_W'(len) << k_reg;
    assign rem_ext = D_W'(rem_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = start_val;
            k_next    = start_k;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_ext >= dshift)
            begin
                rem_next = VAL_W'(rem_ext - dshift);
            end
            if (k_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                k_next = k_reg - K_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        k_reg   <= k_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;

endmodule

`default_nettype wire

[rtl/record_and_interpolated_playback_core.sv]
// Loop recorder with linearly interpolated wavetable playback.
//
// Input channel (in_valid / in_stall) carries one action and one sample per
// item. Begin, record, stop and restart items leave the block idle and give
// no result. A process item advances the read position by phase_step, wraps
// it into the buffer and yields one level item on the output channel
// (out_valid / out_stall).
// A process item runs k + 1 remainder steps in the wrap unit: k is 0 when the
// buffer holds at least 2^(20 - FRAC_BITS) entries, 20 - FRAC_BITS when it is
// shorter, and the width of the advanced position's integer part minus one
// on the first process item after buffer_length was written. Two table reads
// through one memory port and one multiply follow the wrap. With a zero length
// the level is 0. The block takes one item at a time. The result sits in an
// output register: the next item is accepted while it waits, and a further
// process item holds at its final step until the receiver lifts out_stall.
// Reset clears positions and control state, presets phase_step; the table
// reads as zero until written (fill count), so no clearing pass is needed.
// Configuration: cfg_we with cfg_index 0 (buffer_length) or 1 (phase_step),
// to be written by the user only while idle; the block does not enforce it.
`default_nettype none

module record_and_interpolated_playback_core #(
    parameter int TABLE_DEPTH = 16384,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [rip_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [rip_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [rip_pkg::ACTION_W-1:0]        action,
    input  wire logic signed [rip_pkg::SAMPLE_W-1:0] sample,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [rip_pkg::SAMPLE_W-1:0]      level
);

    localparam int SW      = rip_pkg::SAMPLE_W;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int LEN_W   = $clog2(TABLE_DEPTH + 1);
    localparam int STEP_IW = (FRAC_BITS >= rip_pkg::STEP_W) ? 0 : rip_pkg::STEP_W - FRAC_BITS;
    localparam int FAST_LEN = 2 ** STEP_IW;
    localparam int SUM_IW  = $clog2(TABLE_DEPTH + FAST_LEN);
    localparam int POS_W   = SUM_IW + FRAC_BITS;
    localparam int K_W     = $clog2(SUM_IW);
    localparam int CMP_W   = (LEN_W > rip_pkg::LEN_FIELD_W) ? LEN_W : rip_pkg::LEN_FIELD_W;
    localparam int PROD_W  = SW + 2 + FRAC_BITS;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_WRAP = 7'b0000010,
        S_RD0  = 7'b0000100,
        S_RD1  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_SUM  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [LEN_W-1:0]            eff_len_reg, eff_len_next;
    logic [rip_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        stale_reg, stale_next;
    logic [LEN_W-1:0]            wp_reg, wp_next;
    logic [IDX_W-1:0]            rp_int_reg, rp_int_next;
    logic [FRAC_BITS-1:0]        rp_frac_reg, rp_frac_next;
    logic [SW-1:0]               b_reg, b_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic [SW-1:0]               res_reg, res_next;
    logic                        out_valid_reg, out_valid_next;
    logic [SW-1:0]               level_reg, level_next;

    logic                        tbl_we;
    logic [IDX_W-1:0]            tbl_rd_addr;
    logic [SW-1:0]               tbl_rd_data;
    logic                        wrap_start;
    logic [K_W-1:0]              wrap_k;
    rip_pkg::wrap_stat_t         wrap_stat;
    logic [SUM_IW-1:0]           wrap_rem;

    logic [POS_W-1:0]            pos_sum;
    logic [POS_W-1:0]            adv;
    logic [CMP_W-1:0]            bl_ext;
    logic [CMP_W-1:0]            eff_cmp;
    logic [LEN_W-1:0]            next_idx;
    logic [IDX_W-1:0]            above_idx;
    logic signed [SW:0]          diff;
    logic signed [PROD_W-1:0]    prod_full;
    logic signed [SW+1:0]        interp;

    assign pos_sum = {POS_W'(rp_int_reg) << FRAC_BITS} | POS_W'(rp_frac_reg);
    assign adv     = pos_sum + POS_W'(step_reg);

    // length beyond the table is clamped to the table depth
    assign bl_ext  = CMP_W'(cfg_data[rip_pkg::LEN_FIELD_W-1:0]);
    assign eff_cmp = (bl_ext > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH) : bl_ext;

    // entry above wraps to 0 at the end of the buffer
    assign next_idx  = LEN_W'(rp_int_reg) + LEN_W'(1);
    assign above_idx = (next_idx == eff_len_reg) ? '0 : next_idx[IDX_W-1:0];

    assign tbl_rd_addr = (state_reg == S_RD0) ? rp_int_reg : above_idx;

    // level = below + floor((above - below) * frac / 2^F)
    assign diff      = $signed({tbl_rd_data[SW-1], tbl_rd_data}) - $signed({b_reg[SW-1], b_reg});
    assign prod_full = diff * $signed({1'b0, rp_frac_reg});
    assign interp    = $signed((SW + 2)'(prod_reg >>> FRAC_BITS))
                     + $signed({{2{b_reg[SW-1]}}, b_reg});

    always_comb
    begin
        state_next     = state_reg;
        eff_len_next   = eff_len_reg;
        step_next      = step_reg;
        stale_next     = stale_reg;
        wp_next        = wp_reg;
        rp_int_next    = rp_int_reg;
        rp_frac_next   = rp_frac_reg;
        b_next         = b_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        level_next     = level_reg;
        tbl_we         = 1'b0;
        wrap_start     = 1'b0;
        wrap_k         = K_W'(SUM_IW - 1);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (action)
                        rip_pkg::ACT_BEGIN:
                        begin
                            wp_next = '0;
                        end
                        rip_pkg::ACT_RECORD:
                        begin
                            if (wp_reg < eff_len_reg)
                            begin
                                tbl_we  = 1'b1;
                                wp_next = wp_reg + LEN_W'(1);
                            end
                        end
                        rip_pkg::ACT_STOP:
                        begin
                            wp_next      = '0;
                            rp_int_next  = '0;
                            rp_frac_next = '0;
                            stale_next   = 1'b0;
                        end
                        rip_pkg::ACT_RESTART:
                        begin
                            rp_int_next  = '0;
                            rp_frac_next = '0;
                            stale_next   = 1'b0;
                        end
                        rip_pkg::ACT_PROCESS:
                        begin
                            if (eff_len_reg == '0)
                            begin
                                res_next   = '0;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                // start the remainder as low as the bound on the sum allows
                                if (stale_reg)
                                begin
                                    wrap_k = K_W'(SUM_IW - 1);
                                end
                                else if (32'(eff_len_reg) >= 32'(FAST_LEN))
                                begin
                                    wrap_k = '0;
                                end
                                else
                                begin
                                    wrap_k = K_W'(STEP_IW);
                                end
                                wrap_start   = 1'b1;
                                rp_frac_next = adv[FRAC_BITS-1:0];
                                stale_next   = 1'b0;
                                state_next   = S_WRAP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WRAP:
            begin
                if (wrap_stat.done)
                begin
                    rp_int_next = wrap_rem[IDX_W-1:0];
                    state_next  = S_RD0;
                end
            end
            S_RD0:
            begin
                state_next = S_RD1;
            end
            S_RD1:
            begin
                b_next     = tbl_rd_data;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = prod_full;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                res_next   = interp[SW-1:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    level_next     = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                rip_pkg::CFG_BUFFER_LENGTH:
                begin
                    eff_len_next = LEN_W'(eff_cmp);
                    stale_next   = 1'b1;
                end
                rip_pkg::CFG_PHASE_STEP:
                begin
                    step_next = cfg_data[rip_pkg::STEP_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            eff_len_reg   <= '0;
            step_reg      <= rip_pkg::STEP_RESET;
            stale_reg     <= 1'b0;
            wp_reg        <= '0;
            rp_int_reg    <= '0;
            rp_frac_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            eff_len_reg   <= eff_len_next;
            step_reg      <= step_next;
            stale_reg     <= stale_next;
            wp_reg        <= wp_next;
            rp_int_reg    <= rp_int_next;
            rp_frac_reg   <= rp_frac_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg     <= b_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
        level_reg <= level_next;
    end

    rip_table #(
        .DEPTH  (TABLE_DEPTH),
        .IDX_W  (IDX_W),
        .FILL_W (LEN_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_we),
        .wr_addr (wp_reg[IDX_W-1:0]),
        .wr_data (sample),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    rip_wrap #(
        .VAL_W (SUM_IW),
        .LEN_W (LEN_W),
        .K_W   (K_W)
    ) u_wrap (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (wrap_start),
        .start_val (adv[POS_W-1:FRAC_BITS]),
        .start_k   (wrap_k),
        .len       (eff_len_reg),
        .stat      (wrap_stat),
        .rem       (wrap_rem)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign level     = level_reg;

    // the wrapped index always lies inside the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD0) |-> (LEN_W'(rp_int_reg) < eff_len_reg))
        else $error("read index outside buffer after wrap");

    // the wrap unit only finishes while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        wrap_stat.done |-> (state_reg == S_WRAP))
        else $error("wrap finished outside the wrap state");

    // a new result only comes out of the final step
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg ##1 out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

endmodule

`default_nettype wire
